>>> rtl/hcbp_pkg.sv
// Shared types and constants for the Huffman code bit packer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package hcbp_pkg;

    localparam int MAX_CODE_LEN_DEF = 64;
    localparam int QUEUE_DEPTH_DEF  = 2;
    localparam int TREE_W           = 13;
    localparam int IN_CODE_W        = 64;
    localparam int IN_LEN_W         = 7;

    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_ENCODE = 2'd1,
        CMD_FINISH = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_HDR0 = 2'd1,
        KIND_HDR1 = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_PACK,
        BK_FIN0,
        BK_FIN1,
        BK_FIN2
    } back_state_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_flags_t;

endpackage

>>> rtl/huffman_code_bit_packer.sv
// Huffman code bit packer, top level: front lookup, queue, back packer.
// An input item passes the front stage register, the queue and the packer before its first
// output item, output stalls aside. Load: writes the code table, no output. Encode: the
// packer pops the entry, then packs chunks of up to 8 bits into the held byte. Finish: the packer
// pops, then emits the held byte and two headers; at most one output item per cycle.
// Async active-low reset clears control, held byte/count and tree length; code table is kept.
`timescale 1ns / 1ps

module huffman_code_bit_packer
    import hcbp_pkg::*;
#(
    parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [79:0]       s_tdata,   // symbol[7:0], code_bits[71:8], code_length[78:72]
    input  logic [1:0]        s_tuser,   // command[1:0]
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,   // out_byte[7:0]
    output logic [1:0]        m_tuser,   // byte_kind[1:0]
    output logic              m_tlast,
    input  logic              cfg_we,
    input  logic [TREE_W-1:0] cfg_wdata
);

    localparam int CODE_W = MAX_CODE_LEN;
    localparam int LEN_W  = $clog2(MAX_CODE_LEN + 1);
    localparam int Q_W    = CODE_W + LEN_W + 1;

    logic [TREE_W-1:0] tree_len_reg;
    logic              push, pop;
    logic [Q_W-1:0]    push_data, pop_data;
    q_flags_t          q_flags;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tree_len_reg <= '0;
        end
        else if (cfg_we)
        begin
            tree_len_reg <= cfg_wdata;
        end
    end

    hcbp_front #(
        .MAX_CODE_LEN (MAX_CODE_LEN),
        .CODE_W       (CODE_W),
        .LEN_W        (LEN_W)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .command     (s_tuser),
        .symbol      (s_tdata[7:0]),
        .code_bits   (s_tdata[71:8]),
        .code_length (s_tdata[78:72]),
        .push        (push),
        .push_data   (push_data),
        .q_flags     (q_flags)
    );

    hcbp_queue #(
        .WIDTH (Q_W),
        .DEPTH (QUEUE_DEPTH_DEF)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .flags     (q_flags)
    );

    hcbp_back #(
        .MAX_CODE_LEN (MAX_CODE_LEN),
        .CODE_W       (CODE_W),
        .LEN_W        (LEN_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_data  (pop_data),
        .q_flags   (q_flags),
        .pop       (pop),
        .tree_len  (tree_len_reg),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // second header byte follows the first straight away
    a_hdr_order: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tuser == KIND_HDR0) |=> (m_tvalid && m_tuser == KIND_HDR1))
        else $error("header byte 1 did not follow header byte 0");

    a_hdr_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == KIND_HDR1) |-> m_tlast)
        else $error("final header byte without last");

    a_hdr0_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == KIND_HDR0) |-> !m_tlast)
        else $error("first header byte marked last");

    a_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> q_flags.full)
        else $error("input stalled while queue has room");

endmodule

>>> rtl/hcbp_queue.sv
// Short FIFO between the front (table lookup) and the back (bit packer).
// Depends on hcbp_pkg for the flag struct and the default depth.
`timescale 1ns / 1ps

module hcbp_queue
    import hcbp_pkg::*;
#(
    parameter int WIDTH = 72,
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output q_flags_t         flags
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] data_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign flags.full  = (count_reg == CNT_W'(DEPTH));
    assign flags.empty = (count_reg == '0);
    assign do_push     = push && !flags.full;
    assign do_pop      = pop && !flags.empty;
    assign pop_data    = data_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            data_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> rtl/hcbp_front.sv
// Front end: accepts items, writes the code table, looks up codes and
// queues encode/finish work for the packer. Depends on hcbp_pkg.
`timescale 1ns / 1ps

module hcbp_front
    import hcbp_pkg::*;
#(
    parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF,
    parameter int CODE_W       = MAX_CODE_LEN,
    parameter int LEN_W        = $clog2(MAX_CODE_LEN + 1)
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [1:0]                command,
    input  logic [7:0]                symbol,
    input  logic [IN_CODE_W-1:0]      code_bits,
    input  logic [IN_LEN_W-1:0]       code_length,
    output logic                      push,
    output logic [CODE_W+LEN_W:0]     push_data,
    input  q_flags_t                  q_flags
);

    localparam int ENT_W = CODE_W + LEN_W;

    logic [ENT_W-1:0]    table_mem [256];
    logic [ENT_W-1:0]    rd_reg;
    logic                fin_reg;
    logic                st_valid_reg, st_valid_next;
    logic                accept;
    cmd_t                cmd;
    logic [IN_LEN_W-1:0] len_sat;
    logic [IN_CODE_W-1:0] aligned;
    logic [ENT_W-1:0]    wr_entry;

    assign cmd      = cmd_t'(command);
    assign s_tready = !st_valid_reg || !q_flags.full;
    assign accept   = s_tvalid && s_tready;
    assign push     = st_valid_reg && !q_flags.full;
    assign push_data = {fin_reg, rd_reg};

    // code is stored left-aligned so the packer can take bits off the top
    assign len_sat  = (code_length > IN_LEN_W'(MAX_CODE_LEN)) ?
                      IN_LEN_W'(MAX_CODE_LEN) : code_length;
    assign aligned  = code_bits << (IN_LEN_W'(IN_CODE_W) - len_sat);
    assign wr_entry = {LEN_W'(len_sat), aligned[IN_CODE_W-1 -: CODE_W]};

    always_comb
    begin
        st_valid_next = st_valid_reg;
        if (accept && (cmd == CMD_ENCODE || cmd == CMD_FINISH))
        begin
            st_valid_next = 1'b1;
        end
        else if (push)
        begin
            st_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_valid_reg <= 1'b0;
        end
        else
        begin
            st_valid_reg <= st_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && cmd == CMD_LOAD)
        begin
            table_mem[symbol] <= wr_entry;
        end
        if (accept && cmd == CMD_ENCODE)
        begin
            rd_reg <= table_mem[symbol];
        end
        if (accept)
        begin
            fin_reg <= (cmd == CMD_FINISH);
        end
    end

endmodule

>>> rtl/hcbp_back.sv
// Back end: packs code bits MSB-first into bytes, one output byte per
// cycle at most, and emits the held byte plus header on finish. Depends on hcbp_pkg.
`timescale 1ns / 1ps

module hcbp_back
    import hcbp_pkg::*;
#(
    parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF,
    parameter int CODE_W       = MAX_CODE_LEN,
    parameter int LEN_W        = $clog2(MAX_CODE_LEN + 1)
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [CODE_W+LEN_W:0] pop_data,
    input  q_flags_t              q_flags,
    output logic                  pop,
    input  logic [TREE_W-1:0]     tree_len,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,
    output logic [1:0]            m_tuser,
    output logic                  m_tlast
);

    back_state_t       state_reg, state_next;
    logic [CODE_W-1:0] sr_reg, sr_next;
    logic [LEN_W-1:0]  rem_reg, rem_next;
    logic [7:0]        pb_reg, pb_next;
    logic [3:0]        pc_reg, pc_next;
    logic              mv_reg, mv_next;
    logic [7:0]        md_reg, md_next;
    logic [1:0]        mu_reg, mu_next;
    logic              ml_reg, ml_next;

    logic              out_free;
    logic              q_fin;
    logic [LEN_W-1:0]  q_len;
    logic [CODE_W-1:0] q_code;
    logic              full;
    logic [7:0]        base_byte;
    logic [3:0]        base_cnt;
    logic [3:0]        space;
    logic [3:0]        take;
    logic [CODE_W+7:0] ext;
    logic [7:0]        top8;
    logic [2:0]        pad;

    assign {q_fin, q_len, q_code} = pop_data;
    assign out_free = !mv_reg || m_tready;

    // a full held byte goes out only when another bit arrives or on finish
    assign full      = (pc_reg == 4'd8);
    assign base_byte = full ? 8'd0 : pb_reg;
    assign base_cnt  = full ? 4'd0 : pc_reg;
    assign space     = 4'd8 - base_cnt;
    assign take      = (8'(rem_reg) < 8'(space)) ? 4'(rem_reg) : space;
    assign ext       = {sr_reg, 8'h00};
    assign top8      = ext[CODE_W+7 -: 8];
    assign pad       = 3'(4'd8 - pc_reg);

    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;
    assign m_tuser  = mu_reg;
    assign m_tlast  = ml_reg;

    always_comb
    begin
        state_next = state_reg;
        sr_next    = sr_reg;
        rem_next   = rem_reg;
        pb_next    = pb_reg;
        pc_next    = pc_reg;
        mv_next    = mv_reg && !m_tready;
        md_next    = md_reg;
        mu_next    = mu_reg;
        ml_next    = ml_reg;
        pop        = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                if (!q_flags.empty)
                begin
                    pop = 1'b1;
                    if (q_fin)
                    begin
                        state_next = BK_FIN0;
                    end
                    else if (q_len != '0)
                    begin
                        sr_next    = q_code;
                        rem_next   = q_len;
                        state_next = BK_PACK;
                    end
                end
            end
            BK_PACK:
            begin
                if (!full || out_free)
                begin
                    pb_next  = base_byte | (top8 >> base_cnt);
                    pc_next  = base_cnt + take;
                    sr_next  = sr_reg << take;
                    rem_next = rem_reg - LEN_W'(take);
                    if (full)
                    begin
                        mv_next = 1'b1;
                        md_next = pb_reg;
                        mu_next = KIND_DATA;
                        ml_next = (rem_next == '0);
                    end
                    if (rem_next == '0)
                    begin
                        state_next = BK_IDLE;
                    end
                end
            end
            BK_FIN0:
            begin
                if (out_free)
                begin
                    mv_next    = 1'b1;
                    md_next    = pb_reg;
                    mu_next    = KIND_DATA;
                    ml_next    = 1'b0;
                    state_next = BK_FIN1;
                end
            end
            BK_FIN1:
            begin
                if (out_free)
                begin
                    mv_next    = 1'b1;
                    md_next    = {pad, tree_len[12:8]};
                    mu_next    = KIND_HDR0;
                    ml_next    = 1'b0;
                    state_next = BK_FIN2;
                end
            end
            BK_FIN2:
            begin
                if (out_free)
                begin
                    mv_next    = 1'b1;
                    md_next    = tree_len[7:0];
                    mu_next    = KIND_HDR1;
                    ml_next    = 1'b1;
                    pb_next    = 8'd0;
                    pc_next    = 4'd0;
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            rem_reg   <= '0;
            pb_reg    <= 8'd0;
            pc_reg    <= 4'd0;
            mv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rem_reg   <= rem_next;
            pb_reg    <= pb_next;
            pc_reg    <= pc_next;
            mv_reg    <= mv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sr_reg <= sr_next;
        md_reg <= md_next;
        mu_reg <= mu_next;
        ml_reg <= ml_next;
    end

endmodule

>>> dv/tb_huffman_code_bit_packer.sv
// Self-checking testbench for huffman_code_bit_packer: directed and random streams
// of table loads, byte encodes and finishes, checked against an in-bench packer model.
// Depends on rtl/hcbp_pkg.sv and rtl/huffman_code_bit_packer.sv.
`timescale 1ns / 1ps

module tb_huffman_code_bit_packer;
    import hcbp_pkg::*;

    localparam int          MAX_LEN       = MAX_CODE_LEN_DEF;
    localparam int          SETTLE_CYCLES = 48;
    localparam int unsigned CYCLE_LIMIT   = 500000;

    typedef struct packed {
        cmd_t        cmd;
        logic [7:0]  sym;
        logic [63:0] code;
        logic [6:0]  len;
        logic        wait_drain;
    } src_item_t;

    typedef struct packed {
        logic [7:0] data;
        kind_t      kind;
        logic       last;
    } packed_byte_t;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [79:0]       s_tdata   = '0;
    logic [1:0]        s_tuser   = '0;
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [7:0]        m_tdata;
    logic [1:0]        m_tuser;
    logic              m_tlast;
    logic              cfg_we    = 1'b0;
    logic [TREE_W-1:0] cfg_wdata = '0;

    // packer model state
    logic [63:0]       tbl_code [256];
    int                tbl_len  [256];
    logic [7:0]        held_byte;
    int                held_cnt;
    logic [TREE_W-1:0] tree_bits;

    src_item_t    source_items[$];
    packed_byte_t expected_bytes[$];
    src_item_t    cur_item;
    packed_byte_t want;

    logic [7:0]   loaded_syms[$];
    bit           is_loaded[256];
    bit           next_waits_drain;

    int unsigned src_idle_max  = 12;
    int unsigned sink_idle_max = 12;
    int unsigned src_gap;
    int unsigned sink_stall;
    int unsigned cycles;
    int          items_queued;
    int          items_accepted;
    int          results_checked;
    int          mismatches;
    int          n_load, n_encode, n_finish, n_ignored, n_cfg;

    huffman_code_bit_packer #(.MAX_CODE_LEN(MAX_LEN)) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Works out the bytes one accepted item pushes out and queues them.
    function automatic void pack_expected(input src_item_t it);
        packed_byte_t res[$];
        packed_byte_t r;
        logic [63:0]  code;
        logic [2:0]   pad;
        int           len_eff;
        len_eff = 0;
        case (it.cmd)
            CMD_LOAD:
            begin
                n_load++;
                len_eff = (int'(it.len) > MAX_LEN) ? MAX_LEN : int'(it.len);
                code = it.code;
                if (len_eff < 64)
                    code = code & ((64'd1 << len_eff) - 64'd1);
                tbl_code[it.sym] = code;
                tbl_len[it.sym]  = len_eff;
            end
            CMD_ENCODE:
            begin
                n_encode++;
                code = tbl_code[it.sym];
                for (int i = 0; i < tbl_len[it.sym]; i++)
                begin
                    // a full byte only leaves once another bit needs room
                    if (held_cnt >= 8)
                    begin
                        r.data = held_byte;
                        r.kind = KIND_DATA;
                        r.last = 1'b0;
                        res.push_back(r);
                        held_byte = '0;
                        held_cnt  = 0;
                    end
                    if (code[tbl_len[it.sym] - 1 - i])
                        held_byte[7 - held_cnt] = 1'b1;
                    held_cnt++;
                end
            end
            CMD_FINISH:
            begin
                n_finish++;
                pad = 3'((8 - held_cnt) & 7);
                r.last = 1'b0;
                r.data = held_byte;
                r.kind = KIND_DATA;
                res.push_back(r);
                r.data = {pad, tree_bits[12:8]};
                r.kind = KIND_HDR0;
                res.push_back(r);
                r.data = tree_bits[7:0];
                r.kind = KIND_HDR1;
                res.push_back(r);
                held_byte = '0;
                held_cnt  = 0;
            end
            default:
                n_ignored++;
        endcase
        for (int i = 0; i < res.size(); i++)
        begin
            r = res[i];
            r.last = (i == res.size() - 1);
            expected_bytes.push_back(r);
        end
    endfunction

    function automatic void push_item(input cmd_t cmd, input logic [7:0] sym,
                                      input logic [63:0] code, input logic [6:0] len);
        src_item_t it;
        it.cmd        = cmd;
        it.sym        = sym;
        it.code       = code;
        it.len        = len;
        it.wait_drain = next_waits_drain;
        next_waits_drain = 1'b0;
        if (cmd == CMD_LOAD && !is_loaded[sym])
        begin
            is_loaded[sym] = 1'b1;
            loaded_syms.push_back(sym);
        end
        source_items.push_back(it);
        items_queued++;
    endfunction

    // Mostly short codes, some empty, some long, a few beyond the limit.
    function automatic logic [6:0] pick_code_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return 7'd0;
        else if (r < 70)
            return 7'($urandom_range(1, 10));
        else if (r < 92)
            return 7'($urandom_range(11, 64));
        else
            return 7'($urandom_range(65, 127));
    endfunction

    function automatic void queue_random_phase(input int n_items);
        int          n_loads;
        int unsigned r;
        n_loads = int'($urandom_range(4, 16));
        for (int i = 0; i < n_loads; i++)
            push_item(CMD_LOAD, 8'($urandom_range(0, 255)), {$urandom, $urandom},
                      pick_code_len());
        for (int i = n_loads; i < n_items - 1; i++)
        begin
            if (i == n_items / 2)
                next_waits_drain = 1'b1;
            r = $urandom_range(0, 99);
            if (r < 4)
                push_item(CMD_NONE, 8'($urandom_range(0, 255)), {$urandom, $urandom},
                          7'($urandom_range(0, 127)));
            else if (r < 10)
                push_item(CMD_LOAD, 8'($urandom_range(0, 255)), {$urandom, $urandom},
                          pick_code_len());
            else if (r < 16)
                push_item(CMD_FINISH, 8'($urandom_range(0, 255)), {$urandom, $urandom},
                          7'($urandom_range(0, 127)));
            else
                push_item(CMD_ENCODE,
                          loaded_syms[$urandom_range(0, loaded_syms.size() - 1)],
                          {$urandom, $urandom}, 7'($urandom_range(0, 127)));
        end
        push_item(CMD_FINISH, 8'h00, 64'd0, 7'd0);
    endfunction

    // Waits until every item is in and every byte is out, then lets the pipe drain.
    task automatic settle();
        do
            @(negedge clk);
        while (source_items.size() != 0 || items_accepted != items_queued ||
               expected_bytes.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_tree_len(input logic [TREE_W-1:0] v);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        tree_bits = v;
        n_cfg++;
        @(negedge clk);
    endtask

    // Source side
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
            src_gap  = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                pack_expected(cur_item);
                items_accepted++;
            end
            if (s_tvalid && !s_tready)
            begin
                // item still on offer
            end
            else if (src_gap > 0)
            begin
                src_gap--;
                s_tvalid <= 1'b0;
            end
            else if (source_items.size() != 0 &&
                     (!source_items[0].wait_drain || expected_bytes.size() == 0))
            begin
                cur_item = source_items.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {1'b0, cur_item.len, cur_item.code, cur_item.sym};
                s_tuser  <= cur_item.cmd;
                src_gap  = $urandom_range(0, src_idle_max);
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Sink side and checker
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            sink_stall = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_bytes.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected output item: data %02h kind %0d last %0b",
                                 m_tdata, m_tuser, m_tlast);
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    results_checked++;
                    if (m_tdata !== want.data || m_tuser !== want.kind ||
                        m_tlast !== want.last)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"output item %0d: expected data %02h kind %0d last %0b,",
                                      " got data %02h kind %0d last %0b"},
                                     results_checked, want.data, want.kind, want.last,
                                     m_tdata, m_tuser, m_tlast);
                    end
                end
                sink_stall = $urandom_range(0, sink_idle_max);
            end
            if (sink_stall > 0)
            begin
                sink_stall--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        logic [TREE_W-1:0] tv;
        held_byte = '0;
        held_cnt  = 0;
        tree_bits = '0;
        repeat (3) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        // directed: limits, empty and over-long codes, ignored command, empty finish
        set_tree_len(13'h1FFF);
        push_item(CMD_LOAD,   8'h00, 64'hFFFF_FFFF_FFFF_FFFF, 7'd0);
        push_item(CMD_LOAD,   8'hFF, 64'hA5A5_5A5A_C3C3_3C3C, 7'd64);
        push_item(CMD_LOAD,   8'h01, 64'h5A5A_A5A5_3C3C_C3C3, 7'd127);
        push_item(CMD_LOAD,   8'h02, 64'hFFFF_FFFF_FFFF_FFFF, 7'd1);
        push_item(CMD_LOAD,   8'h03, 64'h1234_5678_9ABC_DE96, 7'd8);
        push_item(CMD_LOAD,   8'h80, {$urandom, $urandom},    7'd65);
        push_item(CMD_NONE,   8'hAA, {$urandom, $urandom},    7'h55);
        push_item(CMD_FINISH, 8'h00, 64'd0, 7'd0);
        push_item(CMD_ENCODE, 8'h00, 64'd0, 7'd0);
        push_item(CMD_ENCODE, 8'h03, 64'd0, 7'd0);
        push_item(CMD_FINISH, 8'h00, 64'd0, 7'd0);
        push_item(CMD_ENCODE, 8'h02, 64'd0, 7'd0);
        push_item(CMD_ENCODE, 8'hFF, 64'd0, 7'd0);
        push_item(CMD_ENCODE, 8'h01, 64'd0, 7'd0);
        push_item(CMD_ENCODE, 8'h02, 64'd0, 7'd0);
        push_item(CMD_FINISH, 8'h00, 64'd0, 7'd0);
        push_item(CMD_ENCODE, 8'h80, 64'd0, 7'd0);
        push_item(CMD_ENCODE, 8'h00, 64'd0, 7'd0);
        push_item(CMD_FINISH, 8'h00, 64'd0, 7'd0);
        // full held byte followed by a 64-bit code: eight bytes from one item
        push_item(CMD_ENCODE, 8'h03, 64'd0, 7'd0);
        push_item(CMD_ENCODE, 8'hFF, 64'd0, 7'd0);
        push_item(CMD_FINISH, 8'h00, 64'd0, 7'd0);
        settle();

        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0:       tv = 13'h0000;
                1:       tv = 13'h1555;
                2:       tv = 13'h0AAA;
                default: tv = 13'($urandom);
            endcase
            src_idle_max  = (p == 0 || p == 2) ? 12 : 0;
            sink_idle_max = (p == 0 || p == 3) ? 12 : 0;
            set_tree_len(tv);
            queue_random_phase(80);
            settle();
        end

        $display("checked %0d output items from %0d input items: %0d loads, %0d encodes,",
                 results_checked, items_accepted, n_load, n_encode);
        $display("%0d finishes, %0d ignored commands, %0d tree size writes incl. 0 and 8191",
                 n_finish, n_ignored, n_cfg);
        if (mismatches == 0 && expected_bytes.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

>>> sim.f
rtl/hcbp_pkg.sv
rtl/hcbp_queue.sv
rtl/hcbp_front.sv
rtl/hcbp_back.sv
rtl/huffman_code_bit_packer.sv
dv/tb_huffman_code_bit_packer.sv
